// File: hdl/bb3_pkg.sv
// Shared types, constants and the divide-by-nine helper for the 3x3 box blur.
package bb3_pkg;

  // Frame geometry limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int MIN_SIZE   = 3;
  localparam int LINE_AW    = $clog2(MAX_WIDTH);

  // Field widths
  localparam int CHAN_W = 8;
  localparam int CNT_W  = 11;
  localparam int SIZE_W = 12;
  localparam int COL_W  = 10;  // three channel values summed
  localparam int WIN_W  = 12;  // nine channel values summed

  // Configuration registers
  localparam int CFG_AW    = 3;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  // floor(s / 9) as (s * 7282) >> 16, exact for s below 32768
  localparam int DIV9_MULT_W = 13;
  localparam int DIV9_SHIFT  = 16;
  localparam logic [DIV9_MULT_W-1:0] DIV9_MULT = 13'd7282;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t older;
    pixel_t newer;
  } line_word_t;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } col_sum_t;

  typedef struct packed {
    logic [WIN_W-1:0] red;
    logic [WIN_W-1:0] green;
    logic [WIN_W-1:0] blue;
  } win_sum_t;

  typedef struct packed {
    logic [CHAN_W-1:0] mean_red;
    logic [CHAN_W-1:0] mean_green;
    logic [CHAN_W-1:0] mean_blue;
    logic [CNT_W-1:0]  centre_column;
    logic [CNT_W-1:0]  centre_row;
    logic              frame_done;
  } result_t;

  // Window sum divided by nine, rounded down
  function automatic logic [CHAN_W-1:0] div9(input logic [WIN_W-1:0] s);
    logic [WIN_W+DIV9_MULT_W-1:0] prod;
    prod = {{DIV9_MULT_W{1'b0}}, s} * {{WIN_W{1'b0}}, DIV9_MULT};
    return prod[DIV9_SHIFT +: CHAN_W];
  endfunction

endpackage

// File: hdl/bb3_line_buf.sv
// Two stacked line stores: one memory word holds the pixel two rows up and one row up.
module bb3_line_buf (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [bb3_pkg::LINE_AW-1:0] rd_addr,
  output bb3_pkg::line_word_t        rd_data,
  input  logic                       wr_en,
  input  logic [bb3_pkg::LINE_AW-1:0] wr_addr,
  input  bb3_pkg::line_word_t        wr_data
);

  bb3_pkg::line_word_t mem [bb3_pkg::MAX_WIDTH];
  bb3_pkg::line_word_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/bb3_col_cell.sv
// One window cell: holds the per-channel sum of one 3-pixel column and passes it on.
module bb3_col_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  bb3_pkg::col_sum_t   col_in,
  output bb3_pkg::col_sum_t   col_out
);

  bb3_pkg::col_sum_t col_r;
  bb3_pkg::col_sum_t col_nxt;

  always_comb begin
    col_nxt = shift_en ? col_in : col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_out = col_r;

endmodule

// File: hdl/bb3_out_fifo.sv
// Result queue between the filter pipeline and the output channel.
module bb3_out_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  bb3_pkg::result_t            push_data,
  input  logic                        pop,
  output logic                        not_empty,
  output bb3_pkg::result_t            head,
  output logic [bb3_pkg::FIFO_CW-1:0] count
);

  bb3_pkg::result_t                  entry_r [bb3_pkg::FIFO_DEPTH];
  logic [bb3_pkg::FIFO_AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [bb3_pkg::FIFO_AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [bb3_pkg::FIFO_CW-1:0]       count_r, count_nxt;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign count     = count_r;

endmodule

// File: hdl/box_blur_3x3_rgb.sv
// 3x3 box blur over an RGB raster stream: top level with counters, pipeline and config port.
//
// Takes one RGB pixel per clock in raster order and returns, for each interior pixel, the
// per-channel floor of the 3x3 neighborhood sum divided by nine, tagged with the centre's
// column and row; border pixels give no result and frame_done marks the frame's last result.
// A result passes a three-stage pipeline after the pixel one row below and one column right
// of its centre, then waits in the result queue until out_ready takes it. Sustained rate is
// one pixel per clock, set by the separate read and write ports of the 2048 x 48 bit line
// memory; an eight-entry result queue absorbs output stalls, and in_ready drops only when
// the queue plus results in flight fill it.
// The line memory is not cleared after reset and needs no clearing pass. Frame width and
// height sit at byte addresses 0 and 4, are clamped to 3..2048, and may be changed only
// while the block is idle.
module box_blur_3x3_rgb (
  input  logic                         clk,
  input  logic                         rst_n,
  // pixel input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bb3_pkg::CHAN_W-1:0]   in_pixel_red,
  input  logic [bb3_pkg::CHAN_W-1:0]   in_pixel_green,
  input  logic [bb3_pkg::CHAN_W-1:0]   in_pixel_blue,
  // result output
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bb3_pkg::CHAN_W-1:0]   out_mean_red,
  output logic [bb3_pkg::CHAN_W-1:0]   out_mean_green,
  output logic [bb3_pkg::CHAN_W-1:0]   out_mean_blue,
  output logic [bb3_pkg::CNT_W-1:0]    out_centre_column,
  output logic [bb3_pkg::CNT_W-1:0]    out_centre_row,
  output logic                         out_frame_done,
  // configuration
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [bb3_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  localparam int NUM_CELLS = 3;

  // ---------------- configuration registers ----------------
  logic [bb3_pkg::SIZE_W-1:0]    frame_width_r, frame_width_nxt;
  logic [bb3_pkg::SIZE_W-1:0]    frame_height_r, frame_height_nxt;
  logic [bb3_pkg::REG_IDX_W-1:0] cfg_idx;
  logic                          cfg_wr;

  assign cfg_idx    = cfg_paddr[bb3_pkg::CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_wr) begin
      case (cfg_idx)
        bb3_pkg::REG_FRAME_WIDTH:  frame_width_nxt  = cfg_pwdata[bb3_pkg::SIZE_W-1:0];
        bb3_pkg::REG_FRAME_HEIGHT: frame_height_nxt = cfg_pwdata[bb3_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bb3_pkg::FRAME_WIDTH_RST;
      frame_height_r <= bb3_pkg::FRAME_HEIGHT_RST;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      bb3_pkg::REG_FRAME_WIDTH:
        cfg_prdata = {{(32 - bb3_pkg::SIZE_W){1'b0}}, frame_width_r};
      bb3_pkg::REG_FRAME_HEIGHT:
        cfg_prdata = {{(32 - bb3_pkg::SIZE_W){1'b0}}, frame_height_r};
      default:
        cfg_prdata = '0;
    endcase
  end

  // ---------------- effective frame size ----------------
  logic [bb3_pkg::SIZE_W-1:0] eff_w, eff_h;

  always_comb begin
    if (frame_width_r < bb3_pkg::SIZE_W'(bb3_pkg::MIN_SIZE)) begin
      eff_w = bb3_pkg::SIZE_W'(bb3_pkg::MIN_SIZE);
    end else if (frame_width_r > bb3_pkg::SIZE_W'(bb3_pkg::MAX_WIDTH)) begin
      eff_w = bb3_pkg::SIZE_W'(bb3_pkg::MAX_WIDTH);
    end else begin
      eff_w = frame_width_r;
    end
    if (frame_height_r < bb3_pkg::SIZE_W'(bb3_pkg::MIN_SIZE)) begin
      eff_h = bb3_pkg::SIZE_W'(bb3_pkg::MIN_SIZE);
    end else if (frame_height_r > bb3_pkg::SIZE_W'(bb3_pkg::MAX_HEIGHT)) begin
      eff_h = bb3_pkg::SIZE_W'(bb3_pkg::MAX_HEIGHT);
    end else begin
      eff_h = frame_height_r;
    end
  end

  // ---------------- position counters ----------------
  logic                        in_xfer;
  logic [bb3_pkg::CNT_W-1:0]   col_r, col_nxt, row_r, row_nxt;
  logic [bb3_pkg::CNT_W-1:0]   col_eff, row_eff;
  logic [bb3_pkg::SIZE_W-1:0]  col_inc, row_inc;
  logic                        cur_prod, cur_done;

  assign in_xfer = in_valid && in_ready;

  always_comb begin
    // a count left beyond the frame by a size change restarts at zero
    col_eff = ({1'b0, col_r} >= eff_w) ? '0 : col_r;
    row_eff = ({1'b0, row_r} >= eff_h) ? '0 : row_r;
    col_inc = {1'b0, col_eff} + 1'b1;
    row_inc = {1'b0, row_eff} + 1'b1;

    cur_prod = (col_eff >= bb3_pkg::CNT_W'(2)) && (row_eff >= bb3_pkg::CNT_W'(2));
    cur_done = ({1'b0, col_eff} == eff_w - 1'b1) && ({1'b0, row_eff} == eff_h - 1'b1);

    col_nxt = col_r;
    row_nxt = row_r;
    if (in_xfer) begin
      if (col_inc >= eff_w) begin
        col_nxt = '0;
        row_nxt = (row_inc >= eff_h) ? '0 : row_inc[bb3_pkg::CNT_W-1:0];
      end else begin
        col_nxt = col_inc[bb3_pkg::CNT_W-1:0];
        row_nxt = row_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- stage 1: line memory read ----------------
  logic                       s1_act_r, s1_prod_r, s1_done_r;
  logic [bb3_pkg::CNT_W-1:0]  s1_col_r, s1_row_r;
  bb3_pkg::pixel_t            s1_px_r;
  bb3_pkg::line_word_t        line_rd, line_wr;
  bb3_pkg::col_sum_t          s1_col_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_act_r  <= 1'b0;
      s1_prod_r <= 1'b0;
    end else begin
      s1_act_r  <= in_xfer;
      s1_prod_r <= in_xfer && cur_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_px_r   <= '{red: in_pixel_red, green: in_pixel_green, blue: in_pixel_blue};
      s1_col_r  <= col_eff;
      s1_row_r  <= row_eff;
      s1_done_r <= cur_done;
    end
  end

  bb3_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (col_eff[bb3_pkg::LINE_AW-1:0]),
    .rd_data (line_rd),
    .wr_en   (s1_act_r),
    .wr_addr (s1_col_r[bb3_pkg::LINE_AW-1:0]),
    .wr_data (line_wr)
  );

  // roll the rows: row above moves to two above, new pixel becomes row above
  assign line_wr = '{older: line_rd.newer, newer: s1_px_r};

  // column sum: two rows up + one row up + current pixel
  always_comb begin
    s1_col_sum.red   = bb3_pkg::COL_W'(line_rd.older.red) +
                       bb3_pkg::COL_W'(line_rd.newer.red) +
                       bb3_pkg::COL_W'(s1_px_r.red);
    s1_col_sum.green = bb3_pkg::COL_W'(line_rd.older.green) +
                       bb3_pkg::COL_W'(line_rd.newer.green) +
                       bb3_pkg::COL_W'(s1_px_r.green);
    s1_col_sum.blue  = bb3_pkg::COL_W'(line_rd.older.blue) +
                       bb3_pkg::COL_W'(line_rd.newer.blue) +
                       bb3_pkg::COL_W'(s1_px_r.blue);
  end

  // ---------------- window: chain of column cells ----------------
  bb3_pkg::col_sum_t cell_in  [NUM_CELLS];
  bb3_pkg::col_sum_t cell_out [NUM_CELLS];

  assign cell_in[0] = s1_col_sum;

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    if (c > 0) begin : g_link
      assign cell_in[c] = cell_out[c-1];
    end
    bb3_col_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (s1_act_r),
      .col_in   (cell_in[c]),
      .col_out  (cell_out[c])
    );
  end

  // ---------------- stage 2: window sum ----------------
  logic                       s2_prod_r, s2_done_r;
  logic [bb3_pkg::CNT_W-1:0]  s2_col_r, s2_row_r;
  bb3_pkg::win_sum_t          s2_win_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_prod_r <= 1'b0;
    end else begin
      s2_prod_r <= s1_prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_prod_r) begin
      s2_col_r  <= s1_col_r - 1'b1;
      s2_row_r  <= s1_row_r - 1'b1;
      s2_done_r <= s1_done_r;
    end
  end

  always_comb begin
    s2_win_sum.red   = bb3_pkg::WIN_W'(cell_out[0].red) +
                       bb3_pkg::WIN_W'(cell_out[1].red) +
                       bb3_pkg::WIN_W'(cell_out[2].red);
    s2_win_sum.green = bb3_pkg::WIN_W'(cell_out[0].green) +
                       bb3_pkg::WIN_W'(cell_out[1].green) +
                       bb3_pkg::WIN_W'(cell_out[2].green);
    s2_win_sum.blue  = bb3_pkg::WIN_W'(cell_out[0].blue) +
                       bb3_pkg::WIN_W'(cell_out[1].blue) +
                       bb3_pkg::WIN_W'(cell_out[2].blue);
  end

  // ---------------- stage 3: divide by nine ----------------
  logic                       s3_prod_r, s3_done_r;
  logic [bb3_pkg::CNT_W-1:0]  s3_col_r, s3_row_r;
  bb3_pkg::win_sum_t          s3_sum_r;
  bb3_pkg::result_t           s3_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_prod_r <= 1'b0;
    end else begin
      s3_prod_r <= s2_prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_prod_r) begin
      s3_sum_r  <= s2_win_sum;
      s3_col_r  <= s2_col_r;
      s3_row_r  <= s2_row_r;
      s3_done_r <= s2_done_r;
    end
  end

  always_comb begin
    s3_result.mean_red      = bb3_pkg::div9(s3_sum_r.red);
    s3_result.mean_green    = bb3_pkg::div9(s3_sum_r.green);
    s3_result.mean_blue     = bb3_pkg::div9(s3_sum_r.blue);
    s3_result.centre_column = s3_col_r;
    s3_result.centre_row    = s3_row_r;
    s3_result.frame_done    = s3_done_r;
  end

  // ---------------- result queue and flow control ----------------
  logic                        out_xfer;
  bb3_pkg::result_t            fifo_head;
  logic [bb3_pkg::FIFO_CW-1:0] fifo_count;
  logic [bb3_pkg::FIFO_CW:0]   pending;

  assign out_xfer = out_valid && out_ready;

  bb3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s3_prod_r),
    .push_data (s3_result),
    .pop       (out_xfer),
    .not_empty (out_valid),
    .head      (fifo_head),
    .count     (fifo_count)
  );

  // reserve queue room for every result still in the pipeline
  assign pending = {1'b0, fifo_count} + (bb3_pkg::FIFO_CW + 1)'(s1_prod_r) +
                   (bb3_pkg::FIFO_CW + 1)'(s2_prod_r) + (bb3_pkg::FIFO_CW + 1)'(s3_prod_r);
  assign in_ready = (pending < (bb3_pkg::FIFO_CW + 1)'(bb3_pkg::FIFO_DEPTH));

  assign out_mean_red      = fifo_head.mean_red;
  assign out_mean_green    = fifo_head.mean_green;
  assign out_mean_blue     = fifo_head.mean_blue;
  assign out_centre_column = fifo_head.centre_column;
  assign out_centre_row    = fifo_head.centre_row;
  assign out_frame_done    = fifo_head.frame_done;

endmodule

// File: bench/blur_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the 3x3 RGB box blur bench: pixel-stream predictor and result checker.
package blur_check_pkg;
  import bb3_pkg::*;

  class blur_scoreboard;
    // Shadow copies of the size registers
    logic [SIZE_W-1:0] frame_width_reg;
    logic [SIZE_W-1:0] frame_height_reg;
    // Line memories and the two trailing window columns
    pixel_t            upper_row [MAX_WIDTH];
    pixel_t            prev_row  [MAX_WIDTH];
    pixel_t            window    [6];
    logic [CNT_W-1:0]  col_pos;
    logic [CNT_W-1:0]  row_pos;
    // Blurred pixels still owed by the block, oldest first
    result_t           awaited_means [$];
    int                errors;
    int                pixels_in;
    int                results_checked;
    int                frames_closed;

    function new();
      frame_width_reg  = FRAME_WIDTH_RST;
      frame_height_reg = FRAME_HEIGHT_RST;
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        prev_row[i]  = '0;
      end
      foreach (window[i]) window[i] = '0;
      col_pos         = '0;
      row_pos         = '0;
      errors          = 0;
      pixels_in       = 0;
      results_checked = 0;
      frames_closed   = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 40) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function void set_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
      if (idx == REG_FRAME_WIDTH) frame_width_reg = value[SIZE_W-1:0];
      else frame_height_reg = value[SIZE_W-1:0];
    endfunction

    function void check_register(logic [REG_IDX_W-1:0] idx, logic [31:0] got);
      logic [31:0] want;
      want = (idx == REG_FRAME_WIDTH) ? 32'(frame_width_reg) : 32'(frame_height_reg);
      if (got !== want) report($sformatf("register %0d read %0h, expected %0h", idx, got, want));
    endfunction

    // Size register saturated to the legal frame range
    function int effective_size(logic [SIZE_W-1:0] reg_val, int limit);
      if (reg_val < MIN_SIZE) return MIN_SIZE;
      if (reg_val > limit) return limit;
      return int'(reg_val);
    endfunction

    // Next pixel lands on column 0 of row 0
    function bit frame_start();
      return (col_pos == 0 || int'(col_pos) >= effective_size(frame_width_reg, MAX_WIDTH)) &&
             (row_pos == 0 || int'(row_pos) >= effective_size(frame_height_reg, MAX_HEIGHT));
    endfunction

    function int pending();
      return awaited_means.size();
    endfunction

    // Advance the window by one accepted pixel; queue a blurred result for interior centers
    function void apply_pixel(pixel_t px);
      int      w, h, c, r, idx, sum_r, sum_g, sum_b;
      pixel_t  top, mid;
      pixel_t  hood [9];
      result_t res;
      w = effective_size(frame_width_reg, MAX_WIDTH);
      h = effective_size(frame_height_reg, MAX_HEIGHT);
      c = int'(col_pos);
      r = int'(row_pos);
      // counters left beyond a shrunken frame restart
      if (c >= w) c = 0;
      if (r >= h) r = 0;
      idx = c % MAX_WIDTH;
      top = upper_row[idx];
      mid = prev_row[idx];

      if (c >= 2 && r >= 2) begin
        for (int k = 0; k < 6; k++) hood[k] = window[k];
        hood[6] = top;
        hood[7] = mid;
        hood[8] = px;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        foreach (hood[k]) begin
          sum_r += int'(hood[k].red);
          sum_g += int'(hood[k].green);
          sum_b += int'(hood[k].blue);
        end
        res.mean_red      = CHAN_W'(sum_r / 9);
        res.mean_green    = CHAN_W'(sum_g / 9);
        res.mean_blue     = CHAN_W'(sum_b / 9);
        res.centre_column = CNT_W'(c - 1);
        res.centre_row    = CNT_W'(r - 1);
        res.frame_done    = (c == w - 1 && r == h - 1);
        awaited_means.push_back(res);
      end

      upper_row[idx] = mid;
      prev_row[idx]  = px;
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = top;
      window[4] = mid;
      window[5] = px;

      // raster position of the next pixel
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) begin
          r = 0;
          frames_closed++;
        end
      end
      col_pos = CNT_W'(c);
      row_pos = CNT_W'(r);
      pixels_in++;
    endfunction

    function void compare_field(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want,
                                result_t slot);
      if (got !== want)
        report($sformatf("%s got %0d, expected %0d (center col %0d row %0d)",
                         name, got, want, slot.centre_column, slot.centre_row));
    endfunction

    // Match one output transfer against the oldest owed result
    function void check_result(result_t got);
      result_t want;
      if (awaited_means.size() == 0) begin
        report($sformatf("result with none owed: col %0d row %0d",
                         got.centre_column, got.centre_row));
        return;
      end
      want = awaited_means.pop_front();
      results_checked++;
      compare_field("mean_red", CNT_W'(got.mean_red), CNT_W'(want.mean_red), want);
      compare_field("mean_green", CNT_W'(got.mean_green), CNT_W'(want.mean_green), want);
      compare_field("mean_blue", CNT_W'(got.mean_blue), CNT_W'(want.mean_blue), want);
      compare_field("centre_column", got.centre_column, want.centre_column, want);
      compare_field("centre_row", got.centre_row, want.centre_row, want);
      compare_field("frame_done", CNT_W'(got.frame_done), CNT_W'(want.frame_done), want);
    endfunction
  endclass

endpackage

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Top-level bench for the 3x3 RGB box blur: clock, reset, stimulus, handshakes and verdict.
module tb_top;
  import bb3_pkg::*;
  import blur_check_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PIXELS = 1150;

  typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_FLAT} pixel_style_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic [CHAN_W-1:0]   in_pixel_red   = '0;
  logic [CHAN_W-1:0]   in_pixel_green = '0;
  logic [CHAN_W-1:0]   in_pixel_blue  = '0;
  logic                out_ready      = 1'b0;
  logic                cfg_psel       = 1'b0;
  logic                cfg_penable    = 1'b0;
  logic                cfg_pwrite     = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr      = '0;
  logic [31:0]         cfg_pwdata     = '0;
  logic                in_ready;
  logic                out_valid;
  logic [CHAN_W-1:0]   out_mean_red;
  logic [CHAN_W-1:0]   out_mean_green;
  logic [CHAN_W-1:0]   out_mean_blue;
  logic [CNT_W-1:0]    out_centre_column;
  logic [CNT_W-1:0]    out_centre_row;
  logic                out_frame_done;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  blur_scoreboard sb = new();
  int   cycle_count    = 0;
  int   input_stalls   = 0;
  int   burst_left     = 0;
  int   settings_used  = 0;
  bit   steady_sender  = 1'b0;
  logic hold_pending   = 1'b0;

  box_blur_3x3_rgb u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel_red      (in_pixel_red),
    .in_pixel_green    (in_pixel_green),
    .in_pixel_blue     (in_pixel_blue),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mean_red      (out_mean_red),
    .out_mean_green    (out_mean_green),
    .out_mean_blue     (out_mean_blue),
    .out_centre_column (out_centre_column),
    .out_centre_row    (out_centre_row),
    .out_frame_done    (out_frame_done),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  // 2 ns clock
  initial begin
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("box_blur_3x3_rgb test failed");
    $finish;
  end

  // Output transfers go to the scoreboard; input back-pressure is tallied
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_ready) input_stalls++;
      if (out_valid && out_ready)
        sb.check_result(result_t'{out_mean_red, out_mean_green, out_mean_blue,
                                  out_centre_column, out_centre_row, out_frame_done});
    end
  end

  // Receiver: stretches of open, coin-flip, periodic and sparse readiness, plus one long hold
  initial begin : rx_pattern
    rx_mode_e mode;
    int       stretch;
    int       phase;
    mode    = RX_OPEN;
    stretch = 50;
    phase   = 0;
    forever begin
      if (hold_pending) begin
        out_ready    <= 1'b0;
        hold_pending <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case (mode)
          RX_OPEN:     out_ready <= 1'b1;
          RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: out_ready <= (phase % 5 != 4);
          default:     out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
        phase++;
        stretch--;
        if (stretch == 0) begin
          mode    = rx_mode_e'($urandom_range(0, 3));
          stretch = $urandom_range(10, 150);
        end
      end
    end
  end

  function automatic pixel_t make_pixel(pixel_style_e style);
    pixel_t            px;
    logic [CHAN_W-1:0] gray;
    case (style)
      PIX_EXTREME: begin
        px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      PIX_FLAT: begin
        gray = CHAN_W'($urandom);
        px   = {gray, gray, gray};
      end
      default: px = pixel_t'(24'($urandom));
    endcase
    return px;
  endfunction

  // One pixel transfer; random bursts with random gaps, or one long gapless burst when steady
  task automatic push_pixel(input pixel_t px);
    int gap;
    if (burst_left == 0) begin
      burst_left = steady_sender ? 100000 : $urandom_range(1, 40);
      gap = (steady_sender || $urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_pixel_red   <= px.red;
    in_pixel_green <= px.green;
    in_pixel_blue  <= px.blue;
    do @(posedge clk); while (!in_ready);
    sb.apply_pixel(px);
  endtask

  // Feed pixels until the raster position is back at the top left
  task automatic finish_frame(input pixel_style_e style);
    do push_pixel(make_pixel(style)); while (!sb.frame_start());
  endtask

  // Stop sending, let every owed result come out, then let the pipeline settle
  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup then access phase, then back to idle so back-to-back calls stay clean
  task automatic apb_access(input bit write_op, input logic [REG_IDX_W-1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write_op;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write with junk in the unused upper bits, then read back
  task automatic program_reg(input logic [REG_IDX_W-1:0] idx, input int value);
    logic [31:0] wdata;
    logic [31:0] rdata;
    wdata = {20'($urandom), SIZE_W'(value)};
    apb_access(1'b1, idx, wdata, rdata);
    sb.set_register(idx, wdata);
    apb_access(1'b0, idx, '0, rdata);
    sb.check_register(idx, rdata);
  endtask

  task automatic set_size(input int width_val, input int height_val);
    program_reg(REG_FRAME_WIDTH, width_val);
    program_reg(REG_FRAME_HEIGHT, height_val);
    settings_used++;
  endtask

  initial begin : stimulus
    logic [31:0] rdata;
    int          start_count;
    int          w_reg;
    int          h_reg;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Size registers come up at 640 x 480
    apb_access(1'b0, REG_FRAME_WIDTH, '0, rdata);
    sb.check_register(REG_FRAME_WIDTH, rdata);
    apb_access(1'b0, REG_FRAME_HEIGHT, '0, rdata);
    sb.check_register(REG_FRAME_HEIGHT, rdata);

    // A few pixels at power-up size, then a width below the column count.
    // Both registers under the minimum, so the frame is 3 x 3.
    repeat (5) push_pixel(make_pixel(PIX_UNIFORM));
    wait_drained();
    set_size(0, 1);

    // Smallest frames: full scale, all zero, alternating channel extremes
    repeat (9) push_pixel(pixel_t'(24'hFFFFFF));
    repeat (9) push_pixel(pixel_t'(24'h000000));
    for (int i = 0; i < 9; i++) push_pixel(i % 2 ? pixel_t'(24'h00FF00) : pixel_t'(24'hFF00FF));
    wait_drained();

    // Long receiver hold while pixels keep coming, so the result queue backs up
    set_size(20, 10);
    steady_sender = 1'b1;
    burst_left    = 0;
    hold_pending  <= 1'b1;
    finish_frame(PIX_UNIFORM);
    steady_sender = 1'b0;
    burst_left    = 0;
    finish_frame(PIX_EXTREME);
    wait_drained();

    // Shrink width below the column count, then height below the row count, mid-frame
    set_size(12, 9);
    repeat (5 * 12 + 7) push_pixel(make_pixel(PIX_UNIFORM));
    wait_drained();
    program_reg(REG_FRAME_WIDTH, 5);
    repeat (2 * 5 + 2) push_pixel(make_pixel(PIX_UNIFORM));
    wait_drained();
    program_reg(REG_FRAME_HEIGHT, 4);
    finish_frame(PIX_UNIFORM);
    finish_frame(PIX_FLAT);
    wait_drained();

    // Random small frames, sizes changed only on frame boundaries
    start_count = sb.pixels_in;
    while (sb.pixels_in - start_count < RANDOM_PIXELS) begin
      w_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
      h_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      set_size(w_reg, h_reg);
      repeat ($urandom_range(1, 3)) finish_frame(pixel_style_e'($urandom_range(0, 2)));
      wait_drained();
    end

    // Oversized registers saturate: start of a 2048-wide row, then start of a 2048-tall 3-wide frame
    set_size(4095, 0);
    repeat (64) push_pixel(make_pixel(PIX_UNIFORM));
    wait_drained();
    set_size(1, 4095);
    repeat (3 * 24) push_pixel(make_pixel(PIX_UNIFORM));
    wait_drained();

    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("Covered %0d pixels in %0d frames over %0d size settings, from 3x3 frames to",
             sb.pixels_in, sb.frames_closed, settings_used);
    $display("saturated sizes; %0d results checked, %0d input stall cycles, %0d cycles total.",
             sb.results_checked, input_stalls, cycle_count);
    if (sb.errors == 0) begin
      $display("box_blur_3x3_rgb test passed");
    end else begin
      $display("box_blur_3x3_rgb test failed");
    end
    $finish;
  end

endmodule
